// ===== rtl/core/fptq_pkg.sv =====
// ----------------------------------------------------------------------------
// fptq_pkg: shared types and constants of the path table query unit
// Holds the point, request and result types, the operation and status codes
// and the state types of the sequencer and the multiply-divide unit.
// ----------------------------------------------------------------------------
package fptq_pkg;

    // Table geometry.
    localparam int MAX_POINTS = 256;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;

    // Number of bit steps in each phase of the multiply-divide unit.
    localparam int MD_STEPS = 33;
    localparam int MD_CNT_W = $clog2(MD_STEPS);

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_EVAL   = 2'd2,
        OP_NEAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_FEW  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [31:0] ddl;
        logic signed [31:0] dl;
        logic signed [31:0] l;
        logic signed [31:0] s;
    } t_point;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] point_s;
        logic signed [31:0] point_l;
        logic signed [31:0] point_dl;
        logic signed [31:0] point_ddl;
        logic signed [31:0] query_s;
        logic signed [31:0] box_start_s;
        logic signed [31:0] box_end_s;
        logic signed [31:0] box_start_l;
        logic signed [31:0] box_end_l;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_s;
        logic signed [31:0] out_l;
        logic signed [31:0] out_dl;
        logic signed [31:0] out_ddl;
        t_status            status;
        logic [CNT_W-1:0]   point_count;
    } t_out_item;

    // Request and response of the multiply-divide unit.
    typedef struct packed {
        logic        start;
        logic [32:0] mag;
        logic [31:0] num;
        logic [31:0] den;
    } t_md_req;

    typedef struct packed {
        logic        done;
        logic [32:0] quot;
    } t_md_rsp;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } t_md_phase;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SRCH_A,
        S_SRCH_W,
        S_SRCH_B,
        S_SRCH_END,
        S_PT_W,
        S_PT_USE,
        S_EV_W0,
        S_EV_P0,
        S_EV_W1,
        S_EV_P1,
        S_EV_CHK,
        S_MD_GO,
        S_MD_WAIT,
        S_SCAN_A,
        S_SCAN_W,
        S_SCAN_B,
        S_OUT
    } t_state;

endpackage

// ===== rtl/core/fptq_if.sv =====
// ----------------------------------------------------------------------------
// fptq_if: word channels of the path table query unit
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface fptq_in_if import fptq_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fptq_out_if import fptq_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/fptq_muldiv.sv =====
// ----------------------------------------------------------------------------
// fptq_muldiv: bit-serial multiply then divide
// Computes floor(mag * num / den) with a shift-add multiply of 33 steps
// followed by a restoring divide of 33 steps. Requires num < den.
// ----------------------------------------------------------------------------
module fptq_muldiv import fptq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    t_md_phase           r_phase, n_phase;
    logic                r_done, n_done;
    logic [MD_CNT_W-1:0] r_cnt, n_cnt;
    logic [32:0]         r_mag, n_mag;
    logic [31:0]         r_num, n_num;
    logic [31:0]         r_den, n_den;
    logic [64:0]         r_prod, n_prod;
    logic [31:0]         r_rem, n_rem;
    logic [32:0]         r_quot, n_quot;

    logic                last;
    logic [64:0]         sum;
    logic [32:0]         trial;
    logic                fits;

    assign last  = (r_cnt == MD_CNT_W'(MD_STEPS - 1));
    assign sum   = {r_prod[63:0], 1'b0} + (r_mag[32] ? {33'd0, r_num} : 65'd0);
    assign trial = {r_rem, r_quot[32]};
    assign fits  = (trial >= {1'b0, r_den});

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_mag  <= n_mag;
        r_num  <= n_num;
        r_den  <= n_den;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    // Phase sequencing.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            MD_IDLE: if (i_req.start) n_phase = MD_MUL;
            MD_MUL:  if (last) n_phase = MD_DIV;
            MD_DIV:  if (last) n_phase = MD_IDLE;
            default: n_phase = MD_IDLE;
        endcase
    end

    // One multiply or divide step per cycle.
    always_comb begin
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_mag  = r_mag;
        n_num  = r_num;
        n_den  = r_den;
        n_prod = r_prod;
        n_rem  = r_rem;
        n_quot = r_quot;
        unique case (r_phase)
            MD_IDLE: begin
                if (i_req.start) begin
                    n_cnt  = '0;
                    n_mag  = i_req.mag;
                    n_num  = i_req.num;
                    n_den  = i_req.den;
                    n_prod = '0;
                end
            end
            MD_MUL: begin
                n_prod = sum;
                n_mag  = {r_mag[31:0], 1'b0};
                n_cnt  = r_cnt + 1'b1;
                if (last) begin
                    // The upper part is below den, so it seeds the remainder.
                    n_cnt  = '0;
                    n_rem  = sum[64:33];
                    n_quot = sum[32:0];
                end
            end
            MD_DIV: begin
                n_rem  = fits ? 32'(trial - {1'b0, r_den}) : trial[31:0];
                n_quot = {r_quot[31:0], fits};
                n_cnt  = r_cnt + 1'b1;
                n_done = last;
            end
            default: n_cnt = r_cnt;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== rtl/core/frenet_path_table_query_unit.sv =====
// ----------------------------------------------------------------------------
// frenet_path_table_query_unit: path point table with search by arc length
// Stores up to 256 path points and answers append, clear, evaluate and
// nearest-in-box requests, one result word per request word.
// ----------------------------------------------------------------------------
// The block takes one request word at a time and accepts the next only after
// its result word has been taken. Append and clear go straight to the result.
// Each step of a binary search sets the address, waits for the registered
// read of the point memory and compares. Evaluate costs a search, reads of
// the two neighbor points and, when it interpolates, a pass of the bit-serial
// multiply-divide unit for each of l, dl and ddl. Nearest searches for the
// box start and, unless the first search passes the table end, for the box
// end, then scans the points between until one lies in the box's l-range.
// The memory needs no clearing pass: only entries below the point count are ever read.
// ----------------------------------------------------------------------------
module frenet_path_table_query_unit import fptq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fptq_in_if.sink           i_in,
    fptq_out_if.source        o_out
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_op                r_op, n_op;
    t_in_item           r_in, n_in;
    logic [CNT_W-1:0]   r_first, n_first;
    logic [CNT_W-1:0]   r_len, n_len;
    logic signed [31:0] r_key, n_key;
    logic               r_upper, n_upper;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic [CNT_W-1:0]   r_ptr, n_ptr;
    logic [CNT_W-1:0]   r_best, n_best;
    logic signed [32:0] r_bestd, n_bestd;
    logic               r_have, n_have;
    t_point             r_p0, n_p0;
    t_point             r_p1, n_p1;
    t_point             r_res, n_res;
    t_status            r_status, n_status;
    logic [1:0]         r_fld, n_fld;

    t_point             mem [MAX_POINTS];
    t_point             r_rdata;
    logic               we;

    logic               acc;
    logic               full;
    logic [CNT_W-1:0]   half;
    logic               go;
    logic signed [32:0] num, den;
    logic signed [31:0] x0, x1;
    logic signed [32:0] diff;
    logic signed [32:0] lerp;
    logic signed [32:0] sl, sls, sle, l_dist;
    logic               in_box;
    t_md_req            md_req;
    t_md_rsp            md_rsp;

    assign acc  = i_in.valid && i_in.ready;
    assign full = (r_cnt >= CNT_W'(MAX_POINTS));
    assign half = r_len >> 1;
    assign go   = r_upper ? (r_rdata.s <= r_key) : (r_rdata.s < r_key);
    assign num  = 33'(r_in.query_s) - 33'(r_p0.s);
    assign den  = 33'(r_p1.s) - 33'(r_p0.s);

    // Field being interpolated.
    always_comb begin
        case (r_fld)
            2'd0: begin
                x0 = r_p0.l;
                x1 = r_p1.l;
            end
            2'd1: begin
                x0 = r_p0.dl;
                x1 = r_p1.dl;
            end
            default: begin
                x0 = r_p0.ddl;
                x1 = r_p1.ddl;
            end
        endcase
    end

    assign diff = 33'(x1) - 33'(x0);
    assign lerp = diff[32] ? (33'(x0) - $signed(md_rsp.quot))
                           : (33'(x0) + $signed(md_rsp.quot));

    // Distance of a scanned point from the l-range of the box.
    assign sl     = 33'(r_rdata.l);
    assign sls    = 33'(r_in.box_start_l);
    assign sle    = 33'(r_in.box_end_l);
    assign in_box = (sl >= sls) && (sl <= sle);
    assign l_dist = (sl > sle) ? (sl - sle) : (sls - sl);

    assign md_req.start = (r_state == S_MD_GO);
    assign md_req.mag   = diff[32] ? 33'(-diff) : 33'(diff);
    assign md_req.num   = num[31:0];
    assign md_req.den   = den[31:0];

    fptq_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    // Point memory: one write port, one registered read port.
    assign we = acc && (i_in.data.op == OP_APPEND) && !full;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_cnt[IDX_W-1:0]] <= '{ddl: i_in.data.point_ddl, dl: i_in.data.point_dl,
                                       l: i_in.data.point_l, s: i_in.data.point_s};
        end
        r_rdata <= mem[r_ptr[IDX_W-1:0]];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_in     <= n_in;
        r_first  <= n_first;
        r_len    <= n_len;
        r_key    <= n_key;
        r_upper  <= n_upper;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_ptr    <= n_ptr;
        r_best   <= n_best;
        r_bestd  <= n_bestd;
        r_have   <= n_have;
        r_p0     <= n_p0;
        r_p1     <= n_p1;
        r_res    <= n_res;
        r_status <= n_status;
        r_fld    <= n_fld;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (i_in.data.op)
                        OP_EVAL: n_state = (r_cnt < CNT_W'(2)) ? S_OUT : S_SRCH_A;
                        OP_NEAR: n_state = (r_cnt == '0) ? S_OUT : S_SRCH_A;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_SRCH_A: n_state = (r_len == '0) ? S_SRCH_END : S_SRCH_W;
            S_SRCH_W: n_state = S_SRCH_B;
            S_SRCH_B: n_state = S_SRCH_A;
            S_SRCH_END: begin
                if (r_op == OP_EVAL) begin
                    if (r_first == '0 || r_first >= r_cnt) n_state = S_PT_W;
                    else n_state = S_EV_W0;
                end else if (!r_upper) begin
                    n_state = (r_first >= r_cnt) ? S_PT_W : S_SRCH_A;
                end else begin
                    n_state = S_SCAN_A;
                end
            end
            S_PT_W:   n_state = S_PT_USE;
            S_PT_USE: n_state = S_OUT;
            S_EV_W0:  n_state = S_EV_P0;
            S_EV_P0:  n_state = S_EV_W1;
            S_EV_W1:  n_state = S_EV_P1;
            S_EV_P1:  n_state = S_EV_CHK;
            S_EV_CHK: begin
                if (num <= 0 || den <= 0 || num >= den) n_state = S_OUT;
                else n_state = S_MD_GO;
            end
            S_MD_GO: n_state = S_MD_WAIT;
            S_MD_WAIT: begin
                if (md_rsp.done) n_state = (r_fld == 2'd2) ? S_OUT : S_MD_GO;
            end
            S_SCAN_A: n_state = (r_ptr >= r_hi) ? S_PT_W : S_SCAN_W;
            S_SCAN_W: n_state = S_SCAN_B;
            S_SCAN_B: n_state = in_box ? S_OUT : S_SCAN_A;
            S_OUT:    if (o_out.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath updates of each state.
    always_comb begin
        n_cnt    = r_cnt;
        n_op     = r_op;
        n_in     = r_in;
        n_first  = r_first;
        n_len    = r_len;
        n_key    = r_key;
        n_upper  = r_upper;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_ptr    = r_ptr;
        n_best   = r_best;
        n_bestd  = r_bestd;
        n_have   = r_have;
        n_p0     = r_p0;
        n_p1     = r_p1;
        n_res    = r_res;
        n_status = r_status;
        n_fld    = r_fld;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_in     = i_in.data;
                    n_op     = i_in.data.op;
                    n_res    = '0;
                    n_status = ST_OK;
                    n_first  = '0;
                    n_len    = r_cnt;
                    n_upper  = 1'b0;
                    n_key    = (i_in.data.op == OP_EVAL) ? i_in.data.query_s
                                                         : i_in.data.box_start_s;
                    unique case (i_in.data.op)
                        OP_APPEND: begin
                            if (full) n_status = ST_FULL;
                            else n_cnt = r_cnt + 1'b1;
                        end
                        OP_CLEAR: n_cnt = '0;
                        OP_EVAL:  if (r_cnt < CNT_W'(2)) n_status = ST_FEW;
                        default:  if (r_cnt == '0) n_status = ST_FEW;
                    endcase
                end
            end
            S_SRCH_A: n_ptr = r_first + half;
            S_SRCH_B: begin
                if (go) begin
                    n_first = r_first + half + 1'b1;
                    n_len   = r_len - half - 1'b1;
                end else begin
                    n_len = half;
                end
            end
            S_SRCH_END: begin
                if (r_op == OP_EVAL) begin
                    if (r_first == '0) n_ptr = '0;
                    else if (r_first >= r_cnt) n_ptr = r_cnt - 1'b1;
                    else n_ptr = r_first - 1'b1;
                end else if (!r_upper) begin
                    if (r_first >= r_cnt) begin
                        n_ptr = r_cnt - 1'b1;
                    end else begin
                        // Upper bound of the box end over the rest of the table.
                        n_lo    = r_first;
                        n_len   = r_cnt - r_first;
                        n_key   = r_in.box_end_s;
                        n_upper = 1'b1;
                    end
                end else begin
                    n_hi   = r_first;
                    n_ptr  = r_lo;
                    n_best = r_lo;
                    n_have = 1'b0;
                end
            end
            S_PT_USE: n_res = r_rdata;
            S_EV_P0: begin
                n_p0  = r_rdata;
                n_ptr = r_ptr + 1'b1;
            end
            S_EV_P1: n_p1 = r_rdata;
            S_EV_CHK: begin
                if (num <= 0 || den <= 0) n_res = r_p0;
                else if (num >= den) n_res = r_p1;
                n_res.s = r_in.query_s;
                n_fld   = 2'd0;
            end
            S_MD_WAIT: begin
                if (md_rsp.done) begin
                    case (r_fld)
                        2'd0:    n_res.l   = lerp[31:0];
                        2'd1:    n_res.dl  = lerp[31:0];
                        default: n_res.ddl = lerp[31:0];
                    endcase
                    n_fld = r_fld + 1'b1;
                end
            end
            S_SCAN_A: if (r_ptr >= r_hi) n_ptr = r_best;
            S_SCAN_B: begin
                if (in_box) begin
                    n_res = r_rdata;
                end else begin
                    if (!r_have || l_dist < r_bestd) begin
                        n_have  = 1'b1;
                        n_bestd = l_dist;
                        n_best  = r_ptr;
                    end
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: n_fld = r_fld;
        endcase
    end

    // Channel outputs.
    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = (r_state == S_OUT);
    assign o_out.data.out_s       = r_res.s;
    assign o_out.data.out_l       = r_res.l;
    assign o_out.data.out_dl      = r_res.dl;
    assign o_out.data.out_ddl     = r_res.ddl;
    assign o_out.data.status      = r_status;
    assign o_out.data.point_count = r_cnt;

`ifndef SYNTHESIS
    a_no_accept_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("request word accepted while a result word waits");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS))
        else $error("point count exceeds table depth");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.data.op == OP_APPEND && !full) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("append did not advance the point count");

    a_muldiv_eval_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MD_WAIT) |-> (r_op == OP_EVAL))
        else $error("multiply-divide unit used outside evaluate");
`endif

endmodule
